// ===== hw/rtl/hun_pkg.sv =====
// Shared types and constants of the assignment solver.
// No dependencies; imported by every module of the block but hun_ram.
package hun_pkg;

  localparam int MAX_DIM   = 16;
  localparam int IDX_W     = 4;
  localparam int DIM_W     = 5;
  localparam int ADDR_W    = 2 * IDX_W;
  localparam int CELLS     = MAX_DIM * MAX_DIM;
  localparam int COST_BITS = 16;
  localparam int WORK_W    = 32;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS_USED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_USED = 2'd1;

  typedef struct packed {
    logic [DIM_W-1:0] rows;
    logic [DIM_W-1:0] cols;
    logic [DIM_W-1:0] dim;
  } dims_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [WORK_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

endpackage

// ===== hw/rtl/hun_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module hun_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hw/rtl/hun_ctrl.sv =====
// Solver sequencer: row reduction, Munkres search, adjust, prime and path steps,
// result emission and the clearing pass. Depends on hun_pkg; drives the work RAM.
module hun_ctrl import hun_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              solve_i,
  input  dims_t             dims_i,
  input  logic [WORK_W-1:0] rdata_i,
  output ram_req_t          ram_o,
  output logic              busy_o,
  output logic              out_valid_o,
  output logic [IDX_W-1:0]  out_row_o,
  output logic [IDX_W-1:0]  out_col_o,
  output logic              assigned_o,
  output logic              last_result_o
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_MIN_ROW, S_SUB_ROW, S_COVER, S_FIND, S_ADJ, S_PRIME, S_AUG
  } state_e;

  state_e state_q;

  logic [IDX_W-1:0]  ri_q, cj_q, pi_q, pj_q;
  logic              iss_done_q, pv_q, plast_q;
  logic [ADDR_W-1:0] clr_q;
  logic              emit_en_q;

  logic signed [WORK_W-1:0] min_q, mv_q;
  logic                     found_q;
  logic [IDX_W-1:0]         mi_q, mj_q, cur_r_q, cur_c_q;

  logic [MAX_DIM-1:0] rc_q, cc_q;
  logic [MAX_DIM-1:0] sc_v_q, sr_v_q, pr_v_q;
  logic [IDX_W-1:0]   sc_c_q [MAX_DIM];
  logic [IDX_W-1:0]   sr_r_q [MAX_DIM];
  logic [IDX_W-1:0]   pr_c_q [MAX_DIM];

  logic                     scanning, full_scan, issue, last_cell;
  logic [IDX_W-1:0]         dim_m1;
  logic                     pad;
  logic signed [WORK_W-1:0] rd, eff, adj;
  logic [DIM_W-1:0]         stars;
  logic                     row_asg;

  assign dim_m1    = IDX_W'(dims_i.dim - DIM_W'(1));
  assign scanning  = (state_q == S_MIN_ROW) || (state_q == S_SUB_ROW) ||
                     (state_q == S_FIND) || (state_q == S_ADJ);
  assign full_scan = (state_q == S_FIND) || (state_q == S_ADJ);
  assign issue     = scanning && !iss_done_q;
  assign last_cell = (cj_q == dim_m1) && (!full_scan || (ri_q == dim_m1));

  assign rd  = signed'(rdata_i);
  assign pad = ({1'b0, ri_q} >= dims_i.rows) || ({1'b0, pj_q} >= dims_i.cols);
  assign eff = pad ? '0 : rd;
  assign adj = rd + (rc_q[pi_q] ? mv_q : '0) - (cc_q[pj_q] ? '0 : mv_q);
  assign stars = DIM_W'($countones(sc_v_q));

  // A row counts as assigned only when its star lies in a real column.
  assign row_asg = sc_v_q[clr_q[IDX_W-1:0]] &&
                   ({1'b0, sc_c_q[clr_q[IDX_W-1:0]]} < dims_i.cols);

  always_comb begin
    ram_o       = '0;
    ram_o.raddr = {ri_q, cj_q};
    unique case (state_q)
      S_CLEAR: begin
        ram_o.we    = 1'b1;
        ram_o.waddr = clr_q;
      end
      S_SUB_ROW: begin
        ram_o.we    = pv_q;
        ram_o.waddr = {ri_q, pj_q};
        ram_o.wdata = eff - min_q;
      end
      S_ADJ: begin
        ram_o.we    = pv_q;
        ram_o.waddr = {pi_q, pj_q};
        ram_o.wdata = adj;
      end
      default: ram_o.we = 1'b0;
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_CLEAR;
      clr_q         <= '0;
      emit_en_q     <= 1'b0;
      iss_done_q    <= 1'b1;
      pv_q          <= 1'b0;
      plast_q       <= 1'b0;
      ri_q          <= '0;
      cj_q          <= '0;
      found_q       <= 1'b0;
      rc_q          <= '0;
      cc_q          <= '0;
      sc_v_q        <= '0;
      sr_v_q        <= '0;
      pr_v_q        <= '0;
      out_valid_o   <= 1'b0;
      last_result_o <= 1'b0;
    end else begin
      // Read pipeline: data of the cell issued now arrives next cycle.
      pv_q    <= issue;
      plast_q <= issue && last_cell;
      pi_q    <= ri_q;
      pj_q    <= cj_q;
      if (issue) begin
        if (last_cell) begin
          iss_done_q <= 1'b1;
        end
        if (cj_q == dim_m1) begin
          cj_q <= '0;
          if (full_scan) begin
            ri_q <= ri_q + IDX_W'(1);
          end
        end else begin
          cj_q <= cj_q + IDX_W'(1);
        end
      end
      out_valid_o <= 1'b0;

      unique case (state_q)
        S_CLEAR: begin
          if (emit_en_q && (clr_q < ADDR_W'(dims_i.rows))) begin
            out_valid_o   <= 1'b1;
            out_row_o     <= clr_q[IDX_W-1:0];
            out_col_o     <= row_asg ? sc_c_q[clr_q[IDX_W-1:0]] : '0;
            assigned_o    <= row_asg;
            last_result_o <= (clr_q == ADDR_W'(dims_i.rows - DIM_W'(1)));
          end
          clr_q <= clr_q + ADDR_W'(1);
          if (clr_q == '1) begin
            emit_en_q <= 1'b0;
            sc_v_q    <= '0;
            sr_v_q    <= '0;
            pr_v_q    <= '0;
            rc_q      <= '0;
            cc_q      <= '0;
            state_q   <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (solve_i) begin
            ri_q       <= '0;
            cj_q       <= '0;
            iss_done_q <= 1'b0;
            state_q    <= S_MIN_ROW;
          end
        end
        S_MIN_ROW: begin
          if (pv_q && ((pj_q == '0) || (eff < min_q))) begin
            min_q <= eff;
          end
          if (pv_q && plast_q) begin
            cj_q       <= '0;
            iss_done_q <= 1'b0;
            state_q    <= S_SUB_ROW;
          end
        end
        S_SUB_ROW: begin
          // Greedy starring of the first free zero in the row.
          if (pv_q && (eff == min_q) && !sr_v_q[pj_q] && !sc_v_q[ri_q]) begin
            sc_v_q[ri_q] <= 1'b1;
            sc_c_q[ri_q] <= pj_q;
            sr_v_q[pj_q] <= 1'b1;
            sr_r_q[pj_q] <= ri_q;
          end
          if (pv_q && plast_q) begin
            cj_q <= '0;
            if (ri_q == dim_m1) begin
              ri_q    <= '0;
              state_q <= S_COVER;
            end else begin
              ri_q       <= ri_q + IDX_W'(1);
              iss_done_q <= 1'b0;
              state_q    <= S_MIN_ROW;
            end
          end
        end
        S_COVER: begin
          cc_q <= cc_q | sr_v_q;
          if (stars >= dims_i.dim) begin
            clr_q     <= '0;
            emit_en_q <= 1'b1;
            state_q   <= S_CLEAR;
          end else begin
            ri_q       <= '0;
            cj_q       <= '0;
            iss_done_q <= 1'b0;
            found_q    <= 1'b0;
            state_q    <= S_FIND;
          end
        end
        S_FIND: begin
          if (pv_q && !rc_q[pi_q] && !cc_q[pj_q] && (!found_q || (rd < mv_q))) begin
            found_q <= 1'b1;
            mv_q    <= rd;
            mi_q    <= pi_q;
            mj_q    <= pj_q;
          end
          if (pv_q && plast_q) begin
            ri_q <= '0;
            cj_q <= '0;
            if (!found_q && (rc_q[pi_q] || cc_q[pj_q])) begin
              clr_q     <= '0;
              emit_en_q <= 1'b1;
              state_q   <= S_CLEAR;
            end else begin
              state_q <= S_PRIME;
            end
          end
        end
        S_PRIME: begin
          if (mv_q > 0) begin
            iss_done_q <= 1'b0;
            state_q    <= S_ADJ;
          end else begin
            pr_v_q[mi_q] <= 1'b1;
            pr_c_q[mi_q] <= mj_q;
            if (sc_v_q[mi_q]) begin
              rc_q[mi_q]         <= 1'b1;
              cc_q[sc_c_q[mi_q]] <= 1'b0;
              iss_done_q         <= 1'b0;
              found_q            <= 1'b0;
              state_q            <= S_FIND;
            end else begin
              cur_r_q <= mi_q;
              cur_c_q <= mj_q;
              state_q <= S_AUG;
            end
          end
        end
        S_ADJ: begin
          if (pv_q && plast_q) begin
            ri_q       <= '0;
            cj_q       <= '0;
            iss_done_q <= 1'b0;
            found_q    <= 1'b0;
            state_q    <= S_FIND;
          end
        end
        S_AUG: begin
          // The prime at the current point becomes a star; the star sharing its
          // column is dropped and the walk moves on to the prime in that row.
          sc_v_q[cur_r_q] <= 1'b1;
          sc_c_q[cur_r_q] <= cur_c_q;
          sr_v_q[cur_c_q] <= 1'b1;
          sr_r_q[cur_c_q] <= cur_r_q;
          if (sr_v_q[cur_c_q] && pr_v_q[sr_r_q[cur_c_q]]) begin
            sc_v_q[sr_r_q[cur_c_q]] <= 1'b0;
            cur_r_q <= sr_r_q[cur_c_q];
            cur_c_q <= pr_c_q[sr_r_q[cur_c_q]];
          end else begin
            rc_q    <= '0;
            cc_q    <= '0;
            pr_v_q  <= '0;
            state_q <= S_COVER;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/hungarian_assignment_solver_top.sv =====
// Top level of the Munkres assignment solver: configuration registers, load path
// and the work RAM. Depends on hun_pkg, hun_ram and hun_ctrl.
//
// Cost entries are loaded one item per cycle while busy_o is low; each item
// writes one cell of a 16 by 16 work store. The item flagged last_entry starts
// solving and busy_o stays high until the store is clean again. Solving reads
// the store through its single read port: every minimum search and every cost
// adjustment is a pass over all n*n cells (n the larger of the two dimensions),
// the row reduction makes two passes over each row, and each prime or path
// step is handled by a single state. Results then appear, one per used row in
// ascending order, for a single cycle each under out_valid_o; they cannot be
// held off, so the receiver must take them as they come. They are shown at the
// start of a clearing pass that zeroes all 256 cells of the store; the same
// pass runs after reset, so the block accepts no item until that pass ends.
// Configuration may be written whenever busy_o is low.
module hungarian_assignment_solver_top import hun_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [IDX_W-1:0]            row_index_i,
  input  logic [IDX_W-1:0]            col_index_i,
  input  logic signed [COST_BITS-1:0] cost_i,
  input  logic                        last_entry_i,
  input  logic                        cfg_we_i,
  input  logic [CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [DIM_W-1:0]            cfg_data_i,
  output logic                        out_valid_o,
  output logic [IDX_W-1:0]            out_row_o,
  output logic [IDX_W-1:0]            out_col_o,
  output logic                        assigned_o,
  output logic                        last_result_o
);

  logic [DIM_W-1:0]  rows_q, cols_q;
  dims_t             dims;
  ram_req_t          ctrl_req;
  logic [WORK_W-1:0] rdata;
  logic              load, ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [WORK_W-1:0] ram_wdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= DIM_W'(MAX_DIM);
      cols_q <= DIM_W'(MAX_DIM);
    end else if (cfg_we_i) begin
      if (cfg_index_i == REG_ROWS_USED) begin
        rows_q <= cfg_data_i;
      end else if (cfg_index_i == REG_COLS_USED) begin
        cols_q <= cfg_data_i;
      end
    end
  end

  // A dimension of zero counts as one; anything above the store size saturates.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end
    return r;
  endfunction

  always_comb begin
    dims.rows = clamp_dim(rows_q);
    dims.cols = clamp_dim(cols_q);
    dims.dim  = (dims.rows > dims.cols) ? dims.rows : dims.cols;
  end

  // While idle the RAM write port belongs to the load path.
  assign load      = start_i && !busy_o;
  assign ram_we    = busy_o ? ctrl_req.we : load;
  assign ram_waddr = busy_o ? ctrl_req.waddr : {row_index_i, col_index_i};
  assign ram_wdata = busy_o ? ctrl_req.wdata : WORK_W'(signed'(cost_i));

  hun_ram #(
    .WIDTH(WORK_W),
    .DEPTH(CELLS)
  ) u_work_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ctrl_req.raddr),
    .rdata_o(rdata)
  );

  hun_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .solve_i      (load && last_entry_i),
    .dims_i       (dims),
    .rdata_i      (rdata),
    .ram_o        (ctrl_req),
    .busy_o       (busy_o),
    .out_valid_o  (out_valid_o),
    .out_row_o    (out_row_o),
    .out_col_o    (out_col_o),
    .assigned_o   (assigned_o),
    .last_result_o(last_result_o)
  );

endmodule

// ===== tb/sv/tb_hungarian_assignment_solver_top.sv =====
// Self-checking testbench of the assignment solver: loads random and directed cost
// matrices, predicts the row-to-column assignment and compares every result item.
// Depends on hun_pkg and hungarian_assignment_solver_top only.
module tb_hungarian_assignment_solver_top;
  import hun_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000000;
  localparam int ITEM_TARGET    = 220;

  typedef enum logic [1:0] {MK_NONE, MK_STAR, MK_PRIME} mark_e;

  typedef struct packed {
    logic [IDX_W-1:0]            row;
    logic [IDX_W-1:0]            col;
    logic signed [COST_BITS-1:0] cost;
    logic                        last;
  } entry_t;

  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             assigned;
    logic             last;
  } assign_t;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        start_i = 1'b0;
  logic                        busy_o;
  logic [IDX_W-1:0]            row_index_i = '0;
  logic [IDX_W-1:0]            col_index_i = '0;
  logic signed [COST_BITS-1:0] cost_i = '0;
  logic                        last_entry_i = 1'b0;
  logic                        cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]        cfg_index_i = '0;
  logic [DIM_W-1:0]            cfg_data_i = '0;
  logic                        out_valid_o;
  logic [IDX_W-1:0]            out_row_o;
  logic [IDX_W-1:0]            out_col_o;
  logic                        assigned_o;
  logic                        last_result_o;

  hungarian_assignment_solver_top DUT (.*);

  always #5 clk_i = ~clk_i;

  // Items waiting to be driven, and the assignments still to come out.
  entry_t  entry_fifo[$];
  assign_t expected_assignments[$];

  int  idle_pct = 0;
  int  items_queued = 0;
  int  fail_count = 0;
  int  stall_cycles = 0;
  logic item_taken = 1'b0;

  // Shadow state of the solver: configuration, cost store, marks and covers.
  logic [DIM_W-1:0] rows_cfg = 5'd16;
  logic [DIM_W-1:0] cols_cfg = 5'd16;
  longint cost_store[CELLS];
  mark_e  marks[CELLS];
  bit     row_cov[MAX_DIM];
  bit     col_cov[MAX_DIM];
  int     path_row[2*MAX_DIM];
  int     path_col[2*MAX_DIM];

  function automatic int clamp_dim(logic [DIM_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return int'(v);
  endfunction

  function automatic int mark_in_row(int n, int r, mark_e what);
    for (int j = 0; j < n; j++) if (marks[r*MAX_DIM+j] == what) return j;
    return -1;
  endfunction

  function automatic int star_in_col(int n, int c);
    for (int i = 0; i < n; i++) if (marks[i*MAX_DIM+c] == MK_STAR) return i;
    return -1;
  endfunction

  // Munkres on the leading n x n corner of the shadow store.
  task automatic solve_munkres(int n);
    bit rv[MAX_DIM];
    bit cv[MAX_DIM];
    longint m;
    longint mv;
    int stars, mi, mj, sc, sr, pcl, k;
    bit found;
    rv = '{default: 0};
    cv = '{default: 0};
    // Row reduction, then greedy starring of independent zeros.
    for (int i = 0; i < n; i++) begin
      m = cost_store[i*MAX_DIM];
      for (int j = 1; j < n; j++) if (cost_store[i*MAX_DIM+j] < m) m = cost_store[i*MAX_DIM+j];
      for (int j = 0; j < n; j++) begin
        cost_store[i*MAX_DIM+j] -= m;
        if (cost_store[i*MAX_DIM+j] == 0 && !cv[j] && !rv[i]) begin
          marks[i*MAX_DIM+j] = MK_STAR;
          cv[j] = 1;
          rv[i] = 1;
        end
      end
    end
    forever begin
      stars = 0;
      for (int i = 0; i < n; i++)
        for (int j = 0; j < n; j++)
          if (marks[i*MAX_DIM+j] == MK_STAR) begin
            col_cov[j] = 1;
            stars++;
          end
      if (stars >= n) return;
      forever begin
        found = 0;
        mi = 0;
        mj = 0;
        mv = 0;
        for (int i = 0; i < n; i++) begin
          if (row_cov[i]) continue;
          for (int j = 0; j < n; j++) begin
            if (col_cov[j]) continue;
            if (!found || cost_store[i*MAX_DIM+j] < mv) begin
              found = 1;
              mv = cost_store[i*MAX_DIM+j];
              mi = i;
              mj = j;
            end
          end
        end
        if (!found) return;
        if (mv > 0) begin
          for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++) begin
              if (row_cov[i]) cost_store[i*MAX_DIM+j] += mv;
              if (!col_cov[j]) cost_store[i*MAX_DIM+j] -= mv;
            end
          continue;
        end
        marks[mi*MAX_DIM+mj] = MK_PRIME;
        sc = mark_in_row(n, mi, MK_STAR);
        if (sc >= 0) begin
          row_cov[mi] = 1;
          col_cov[sc] = 0;
          continue;
        end
        // Augmenting path of alternating primes and stars.
        k = 0;
        path_row[0] = mi;
        path_col[0] = mj;
        forever begin
          sr = star_in_col(n, path_col[k]);
          if (sr < 0) break;
          pcl = mark_in_row(n, sr, MK_PRIME);
          if (pcl < 0 || k + 2 >= 2*MAX_DIM) break;
          k++;
          path_row[k] = sr;
          path_col[k] = path_col[k-1];
          k++;
          path_row[k] = sr;
          path_col[k] = pcl;
        end
        for (int p = 0; p <= k; p++)
          marks[path_row[p]*MAX_DIM+path_col[p]] =
            (marks[path_row[p]*MAX_DIM+path_col[p]] == MK_STAR) ? MK_NONE : MK_STAR;
        row_cov = '{default: 0};
        col_cov = '{default: 0};
        foreach (marks[p]) if (marks[p] == MK_PRIME) marks[p] = MK_NONE;
        break;
      end
    end
  endtask

  // Stores an accepted entry; on the last one solves and queues the assignments.
  task automatic predict_assignment(entry_t e);
    int r_dim, c_dim, n, col;
    assign_t res;
    cost_store[e.row*MAX_DIM+e.col] = longint'(e.cost);
    if (!e.last) return;
    r_dim = clamp_dim(rows_cfg);
    c_dim = clamp_dim(cols_cfg);
    n = (r_dim > c_dim) ? r_dim : c_dim;
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++)
        if (i >= r_dim || j >= c_dim) cost_store[i*MAX_DIM+j] = 0;
    marks = '{default: MK_NONE};
    row_cov = '{default: 0};
    col_cov = '{default: 0};
    solve_munkres(n);
    for (int i = 0; i < r_dim; i++) begin
      col = -1;
      for (int j = 0; j < c_dim; j++) if (marks[i*MAX_DIM+j] == MK_STAR) col = j;
      res.row      = i[IDX_W-1:0];
      res.col      = (col >= 0) ? col[IDX_W-1:0] : '0;
      res.assigned = (col >= 0);
      res.last     = (i + 1 == r_dim);
      expected_assignments.push_back(res);
    end
    cost_store = '{default: 0};
    marks = '{default: MK_NONE};
    row_cov = '{default: 0};
    col_cov = '{default: 0};
  endtask

  // Driver: a new item is presented only once the previous one has been taken,
  // so start_i gets at most one update per falling edge.
  always @(negedge clk_i) begin
    if (rst_ni && (!start_i || item_taken)) begin
      if (entry_fifo.size() != 0 && $urandom_range(99) >= idle_pct) begin
        entry_t e;
        e = entry_fifo.pop_front();
        start_i      <= 1'b1;
        row_index_i  <= e.row;
        col_index_i  <= e.col;
        cost_i       <= e.cost;
        last_entry_i <= e.last;
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // Monitor: tracks acceptance, the configuration, the result checks and the watchdog.
  always @(posedge clk_i) begin
    assign_t got, want;
    item_taken <= start_i && !busy_o && rst_ni;
    if (rst_ni) begin
      if (cfg_we_i) begin
        if (cfg_index_i == REG_ROWS_USED) rows_cfg = cfg_data_i;
        else if (cfg_index_i == REG_COLS_USED) cols_cfg = cfg_data_i;
      end
      if (start_i && !busy_o)
        predict_assignment('{row_index_i, col_index_i, cost_i, last_entry_i});
      if (out_valid_o) begin
        got = '{out_row_o, out_col_o, assigned_o, last_result_o};
        if (expected_assignments.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result: row %0d col %0d", got.row, got.col);
        end else begin
          want = expected_assignments.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected row %0d col %0d asg %0b last %0b, got %0d %0d %0b %0b",
                       want.row, want.col, want.assigned, want.last,
                       got.row, got.col, got.assigned, got.last);
          end
        end
      end
      if ((start_i && !busy_o) || out_valid_o) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic push_entry(int r, int c, int cost, bit last = 1'b0);
    entry_fifo.push_back('{r[IDX_W-1:0], c[IDX_W-1:0], cost[COST_BITS-1:0], last});
    items_queued++;
  endtask

  // Waits until every item is in and every assignment is out, with the block idle.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (entry_fifo.size() != 0 || start_i || expected_assignments.size() != 0 || busy_o);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_dims(int rows, int cols);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_ROWS_USED;
    cfg_data_i  <= rows[DIM_W-1:0];
    @(negedge clk_i);
    cfg_index_i <= REG_COLS_USED;
    cfg_data_i  <= cols[DIM_W-1:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // One random problem: small ones load every cell in shuffled order, large ones
  // only a few cells, leaving the rest at zero. Some noise lands anywhere.
  task automatic random_problem();
    int rows, cols, r_dim, c_dim, cells[$], tmp, sw, narrow, noise;
    if ($urandom_range(99) < 6) begin
      rows = $urandom_range(6, 16);
      cols = $urandom_range(6, 16);
    end else begin
      rows = $urandom_range(1, 5);
      cols = $urandom_range(1, 5);
    end
    if ($urandom_range(99) < 8) rows = ($urandom_range(1) != 0) ? 0 : $urandom_range(17, 31);
    if ($urandom_range(99) < 8) cols = ($urandom_range(1) != 0) ? 0 : $urandom_range(17, 31);
    write_dims(rows, cols);
    r_dim = clamp_dim(rows[DIM_W-1:0]);
    c_dim = clamp_dim(cols[DIM_W-1:0]);
    if (r_dim * c_dim <= 25) begin
      for (int p = 0; p < r_dim * c_dim; p++) cells.push_back(p);
      for (int p = cells.size() - 1; p > 0; p--) begin
        sw = $urandom_range(p);
        tmp = cells[p];
        cells[p] = cells[sw];
        cells[sw] = tmp;
      end
    end else begin
      repeat ($urandom_range(4, 12)) cells.push_back($urandom_range(r_dim * c_dim - 1));
    end
    narrow = ($urandom_range(1) != 0);
    noise = ($urandom_range(99) < 20) ? $urandom_range(1, 2) : 0;
    foreach (cells[p])
      push_entry(cells[p] / c_dim, cells[p] % c_dim,
                 narrow ? $urandom_range(8) - 4 : $urandom_range(65535),
                 (noise == 0) && (p == cells.size() - 1));
    for (int q = 0; q < noise; q++)
      push_entry($urandom_range(15), $urandom_range(15), $urandom_range(65535), q == noise - 1);
  endtask

  initial begin
    cost_store = '{default: 0};
    marks = '{default: MK_NONE};
    row_cov = '{default: 0};
    col_cov = '{default: 0};
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: single cell at the most negative cost.
    write_dims(1, 1);
    push_entry(0, 0, -32768, 1);
    // Zero dimensions read as one; the only entry lies outside the used corner.
    write_dims(0, 0);
    push_entry(15, 15, 32767, 1);
    // More rows than columns: one row must end up on padding.
    write_dims(3, 2);
    push_entry(0, 0, 5);
    push_entry(0, 1, 1);
    push_entry(1, 0, 2);
    push_entry(1, 1, 7);
    push_entry(2, 0, -3);
    push_entry(2, 1, -3, 1);
    // Oversized column count saturates; most cells left unloaded.
    write_dims(2, 31);
    push_entry(0, 3, -100);
    push_entry(1, 3, -200);
    push_entry(1, 15, 32767, 1);
    // Full size with extreme costs and ties, all on a sparse load.
    write_dims(16, 16);
    push_entry(0, 0, 32767);
    push_entry(15, 15, -32768);
    push_entry(7, 8, -32768);
    push_entry(8, 7, 32767);
    push_entry(3, 12, 1);
    push_entry(12, 3, -1, 1);
    // Fewer rows than columns, tied costs everywhere.
    write_dims(2, 4);
    for (int p = 0; p < 8; p++) push_entry(p / 4, p % 4, 3, p == 7);

    // Random problems, through phases with and without sender gaps.
    while (items_queued < ITEM_TARGET) begin
      idle_pct = (items_queued < 80) ? 0 : (items_queued < 140) ? 75 :
                 (items_queued < 190) ? 19 : 0;
      random_problem();
    end

    wait_idle();
    repeat (300) @(negedge clk_i);
    fail_count += expected_assignments.size();
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
